// File: hw/rtl/sixadsr_pkg.sv
// Shared types, codes and the noise period helper function of the six-voice envelope engine.
package sixadsr_pkg;

	localparam int INSTRUMENTS_DEFAULT = 8;
	localparam int NOTE_COUNT_DEFAULT  = 96;
	localparam int QUEUE_DEPTH         = 2;

	localparam logic [2:0] CMD_NOTE_ON   = 3'd0;
	localparam logic [2:0] CMD_NOTE_OFF  = 3'd1;
	localparam logic [2:0] CMD_SET_INSTR = 3'd2;
	localparam logic [2:0] CMD_LOAD      = 3'd3;
	localparam logic [2:0] CMD_TICK      = 3'd4;
	localparam logic [2:0] CMD_ALL_OFF   = 3'd5;

	localparam logic [1:0] KIND_TONE  = 2'd0;
	localparam logic [1:0] KIND_NOISE = 2'd1;
	localparam logic [1:0] KIND_AMP   = 2'd2;
	localparam logic [1:0] KIND_MIXER = 2'd3;

	localparam logic [2:0] PHASE_OFF  = 3'd0;
	localparam logic [2:0] PHASE_RISE = 3'd1;
	localparam logic [2:0] PHASE_FALL = 3'd2;
	localparam logic [2:0] PHASE_HOLD = 3'd3;
	localparam logic [2:0] PHASE_FADE = 3'd4;

	localparam logic [2:0] VOICES       = 3'd6;
	localparam logic [5:0] MIXER_ALL    = 6'h3F;
	localparam logic [7:0] NOISE_LOW    = 8'd13;
	localparam logic [7:0] NOISE_HIGH   = 8'd43;
	localparam logic [7:0] NOISE_BASE   = 8'd44;
	localparam logic [7:0] PERIOD_MAX   = 8'd31;
	localparam logic [7:0] PERIOD_MIN   = 8'd1;
	localparam logic [7:0] LAST_UNKNOWN = 8'hFF;

	localparam logic [1:0] ADDR_ATTENUATION = 2'd0;
	localparam logic [1:0] ADDR_CHIP_COUNT  = 2'd1;

	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] voice;
		logic [7:0] note;
		logic [2:0] instrument;
		logic [3:0] peak;
		logic [7:0] attack_rate;
		logic [7:0] decay_rate;
		logic [3:0] sustain;
		logic [7:0] release_rate;
		logic       noise_flag;
		logic [7:0] arp_first;
		logic [7:0] arp_second;
	} in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] voice_res;
		logic       chip;
		logic [7:0] value;
		logic       last;
	} out_t;

	typedef struct packed {
		logic [3:0] peak;
		logic [7:0] atk;
		logic [7:0] dec;
		logic [3:0] sus;
		logic [7:0] rel;
		logic       flg;
		logic [7:0] ar1;
		logic [7:0] ar2;
	} instr_t;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] voice;
		logic [7:0] note;
		logic [2:0] instrument;
		instr_t     data;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t data;
	} qhead_t;

	function automatic logic [7:0] noise_period(input logic [7:0] n);
		logic [7:0] p;
		if (n < NOISE_LOW)
			p = PERIOD_MAX;
		else if (n > NOISE_HIGH)
			p = PERIOD_MIN;
		else
			p = NOISE_BASE - n;
		return p;
	endfunction

endpackage

// File: hw/rtl/six_voice_adsr_envelope_engine_core.sv
// Top level of the six-voice envelope engine: configuration registers and wiring.
//
// Requests arrive on req and are taken at a rising edge where start is high
// and busy is low. Busy rises only when the two-entry command queue is full.
// Requests that change nothing (bad voice, unknown command, loading an
// instrument slot that does not exist) are dropped at the front end.
// The engine takes one queued request at a time. Note off, set instrument,
// load instrument and all voices off are done in the idle state alone. Note
// on passes through a closing state and gives at most one write. A frame
// tick takes the request, visits each of the six voices in ST_VA and ST_VB,
// then ST_MIX0, ST_MIX1 and ST_FLUSH, and yields up to fourteen writes.
// Each write appears on result for exactly one cycle with result_strobe high;
// it is kept pending until the next write is produced or the request closes,
// and the final write of a request carries last. The receiver cannot stall,
// so no write ever waits for it.
// Reset clears the instrument table, all voice state and the queue, marks
// every last-written amplitude and mixer byte unknown, sets attenuation to
// zero and chip count to two. The APB port holds attenuation at byte
// address 0 and chip count at byte address 4; pready is always high.
module six_voice_adsr_envelope_engine_core #(
	parameter int INSTRUMENTS = sixadsr_pkg::INSTRUMENTS_DEFAULT,
	parameter int NOTE_COUNT  = sixadsr_pkg::NOTE_COUNT_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sixadsr_pkg::in_t  req,
	output logic              result_strobe,
	output sixadsr_pkg::out_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [3:0] attenuation_q;
	logic [1:0] chip_count_q;
	logic       q_full;
	logic       push;
	logic       pop;
	sixadsr_pkg::qent_t  entry;
	sixadsr_pkg::qhead_t head;
	logic [1:0] reg_sel;

	// Registers are word spaced; the word index picks the register.
	assign reg_sel = {1'b0, paddr[2]};
	assign pready  = 1'b1;

	always_comb begin
		case (reg_sel)
			sixadsr_pkg::ADDR_ATTENUATION: prdata = {28'b0, attenuation_q};
			sixadsr_pkg::ADDR_CHIP_COUNT:  prdata = {30'b0, chip_count_q};
			default:                       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attenuation_q <= '0;
			chip_count_q  <= 2'd2;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				sixadsr_pkg::ADDR_ATTENUATION: attenuation_q <= pwdata[3:0];
				sixadsr_pkg::ADDR_CHIP_COUNT:  chip_count_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	sixadsr_front #(.INSTRUMENTS(INSTRUMENTS)) u_front (
		.start  (start),
		.req    (req),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.entry  (entry)
	);

	sixadsr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	sixadsr_back #(.INSTRUMENTS(INSTRUMENTS), .NOTE_COUNT(NOTE_COUNT)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.attenuation   (attenuation_q),
		.chip_count    (chip_count_q),
		.result_strobe (result_strobe),
		.result        (result)
	);

`ifndef SYNTHESIS
	// Amplitude writes are four-bit levels after attenuation.
	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind == sixadsr_pkg::KIND_AMP |-> result.value < 8'd16)
		else $error("amplitude write out of range");

	// Mixer writes carry voice zero and a six-bit byte.
	a_mix_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind == sixadsr_pkg::KIND_MIXER |->
		result.voice_res == 3'd0 && result.value < 8'd64)
		else $error("malformed mixer write");

	// Voice writes go to the chip that owns the voice.
	a_voice_chip: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind != sixadsr_pkg::KIND_MIXER |->
		result.voice_res < 3'd6 && result.chip == (result.voice_res >= 3'd3))
		else $error("voice write on wrong chip");

	// The second mixer write needs the second chip to be present.
	a_chip1_mix: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.kind == sixadsr_pkg::KIND_MIXER && result.chip |->
		chip_count_q == 2'd2)
		else $error("mixer write to absent chip");
`endif

endmodule

// File: hw/rtl/sixadsr_front.sv
// Command front end: accepts requests, drops those that do nothing, queues the rest.
module sixadsr_front #(
	parameter int INSTRUMENTS = sixadsr_pkg::INSTRUMENTS_DEFAULT
) (
	input  logic                start,
	input  sixadsr_pkg::in_t    req,
	input  logic                q_full,
	output logic                busy,
	output logic                push,
	output sixadsr_pkg::qent_t  entry
);

	logic keep;

	always_comb begin
		keep = 1'b0;
		case (req.cmd)
			sixadsr_pkg::CMD_NOTE_ON,
			sixadsr_pkg::CMD_NOTE_OFF,
			sixadsr_pkg::CMD_SET_INSTR: keep = (req.voice < sixadsr_pkg::VOICES);
			sixadsr_pkg::CMD_LOAD:      keep = (32'(req.instrument) < INSTRUMENTS);
			sixadsr_pkg::CMD_TICK,
			sixadsr_pkg::CMD_ALL_OFF:   keep = 1'b1;
			default:                    keep = 1'b0;
		endcase
	end

	assign busy = q_full;
	assign push = start & ~q_full & keep;

	always_comb begin
		entry            = '0;
		entry.op         = req.cmd;
		entry.voice      = req.voice;
		entry.note       = req.note;
		entry.instrument = req.instrument;
		entry.data.peak  = req.peak;
		entry.data.atk   = req.attack_rate;
		entry.data.dec   = req.decay_rate;
		entry.data.sus   = req.sustain;
		entry.data.rel   = req.release_rate;
		entry.data.flg   = req.noise_flag;
		entry.data.ar1   = req.arp_first;
		entry.data.ar2   = req.arp_second;
	end

endmodule

// File: hw/rtl/sixadsr_queue.sv
// Short command queue between the front end and the engine.
module sixadsr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sixadsr_pkg::qent_t  entry,
	input  logic                pop,
	output logic                full,
	output sixadsr_pkg::qhead_t head
);

	localparam int PW = (sixadsr_pkg::QUEUE_DEPTH > 1) ? $clog2(sixadsr_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(sixadsr_pkg::QUEUE_DEPTH + 1);

	sixadsr_pkg::qent_t mem_q [sixadsr_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full       = (32'(count_q) == sixadsr_pkg::QUEUE_DEPTH);
	assign head.valid = (count_q != '0);
	assign head.data  = mem_q[rd_q];
	assign do_pop     = pop & head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				mem_q[wr_q] <= entry;
				wr_q <= (32'(wr_q) == sixadsr_pkg::QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (do_pop)
				rd_q <= (32'(rd_q) == sixadsr_pkg::QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: hw/rtl/sixadsr_back.sv
// Envelope engine: carries out queued commands and emits register writes.
module sixadsr_back #(
	parameter int INSTRUMENTS = sixadsr_pkg::INSTRUMENTS_DEFAULT,
	parameter int NOTE_COUNT  = sixadsr_pkg::NOTE_COUNT_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sixadsr_pkg::qhead_t head,
	output logic                pop,
	input  logic [3:0]          attenuation,
	input  logic [1:0]          chip_count,
	output logic                result_strobe,
	output sixadsr_pkg::out_t   result
);

	localparam int IW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_VA    = 3'd1;
	localparam logic [2:0] ST_VB    = 3'd2;
	localparam logic [2:0] ST_MIX0  = 3'd3;
	localparam logic [2:0] ST_MIX1  = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	sixadsr_pkg::instr_t tbl_q [INSTRUMENTS];
	logic [2:0] vinst_q [6];
	logic [2:0] phase_q [6];
	logic [7:0] amp_q   [6];
	logic [7:0] lout_q  [6];
	logic [7:0] note_q  [6];
	logic [1:0] arp_q   [6];
	logic       noise_q [6];
	logic [7:0] lmix_q  [2];
	logic [5:0] mix_q   [2];

	logic [2:0] state_q;
	logic [2:0] v_q;
	logic       amp_emit_q;
	logic [7:0] amp_val_q;
	logic       pend_v_q;
	sixadsr_pkg::out_t pend_q;

	logic [2:0]          sel_v;
	sixadsr_pkg::instr_t inst;
	logic                chip;
	logic [2:0]          mix_bit;
	logic                skip;
	logic [2:0]          nph;
	logic [7:0]          namp;
	logic [7:0]          pk, su;
	logic [8:0]          sum9, dlim9;
	logic                arp_go;
	logic [1:0]          nstep;
	logic [7:0]          pnote;
	logic [3:0]          alev;
	logic [3:0]          aatt;
	logic                aemit;
	logic                prod_v;
	sixadsr_pkg::out_t   prod;
	logic [7:0]          pitch_note;
	logic                pitch_noise;

	// Voice under attention and its instrument
	always_comb begin
		sel_v = (state_q == ST_IDLE) ? head.data.voice : v_q;
		if (32'(vinst_q[sel_v]) < INSTRUMENTS)
			inst = tbl_q[IW'(vinst_q[sel_v])];
		else
			inst = '0;
		chip    = (sel_v >= 3'd3);
		mix_bit = chip ? sel_v - 3'd3 : sel_v;
		if (noise_q[sel_v])
			mix_bit = mix_bit + 3'd3;
	end

	// Envelope step for one voice
	always_comb begin
		pk    = {inst.peak, 4'b0};
		su    = {inst.sus, 4'b0};
		nph   = phase_q[sel_v];
		namp  = amp_q[sel_v];
		skip  = (phase_q[sel_v] == sixadsr_pkg::PHASE_OFF) && (lout_q[sel_v] == 8'd0);
		sum9  = {1'b0, amp_q[sel_v]} + {1'b0, inst.atk};
		dlim9 = {1'b0, su} + {1'b0, inst.dec};
		case (phase_q[sel_v])
			sixadsr_pkg::PHASE_RISE: begin
				if (sum9 >= {1'b0, pk}) begin
					namp = pk;
					nph  = sixadsr_pkg::PHASE_FALL;
				end else begin
					namp = sum9[7:0];
				end
			end
			sixadsr_pkg::PHASE_FALL: begin
				if (inst.dec == 8'd0 || {1'b0, amp_q[sel_v]} <= dlim9) begin
					namp = su;
					nph  = (su != 8'd0) ? sixadsr_pkg::PHASE_HOLD : sixadsr_pkg::PHASE_OFF;
				end else begin
					namp = amp_q[sel_v] - inst.dec;
				end
			end
			sixadsr_pkg::PHASE_FADE: begin
				if (inst.rel == 8'd0 || amp_q[sel_v] <= inst.rel) begin
					namp = 8'd0;
					nph  = sixadsr_pkg::PHASE_OFF;
				end else begin
					namp = amp_q[sel_v] - inst.rel;
				end
			end
			default: ;
		endcase
		arp_go = (nph != sixadsr_pkg::PHASE_OFF) && ((inst.ar1 != 8'd0) || (inst.ar2 != 8'd0));
		nstep  = (arp_q[sel_v] >= 2'd2) ? 2'd0 : arp_q[sel_v] + 2'd1;
		case (nstep)
			2'd1:    pnote = note_q[sel_v] + inst.ar1;
			2'd2:    pnote = note_q[sel_v] + inst.ar2;
			default: pnote = note_q[sel_v];
		endcase
		alev  = namp[7:4];
		aemit = ({4'b0, alev} != lout_q[sel_v]);
		aatt  = (alev > attenuation) ? alev - attenuation : 4'd0;
	end

	// One produced write per cycle at most
	always_comb begin
		pop         = 1'b0;
		prod_v      = 1'b0;
		prod        = '0;
		pitch_noise = noise_q[sel_v];
		pitch_note  = pnote;
		if (state_q == ST_IDLE) begin
			pitch_noise = inst.flg;
			pitch_note  = head.data.note;
		end
		case (state_q)
			ST_IDLE: begin
				pop = head.valid;
				if (head.valid && head.data.op == sixadsr_pkg::CMD_NOTE_ON)
					prod_v = pitch_noise || (32'(pitch_note) < NOTE_COUNT);
			end
			ST_VA:   prod_v = !skip && arp_go &&
				(pitch_noise || (32'(pitch_note) < NOTE_COUNT));
			default: ;
		endcase
		if (state_q == ST_IDLE || state_q == ST_VA) begin
			prod.kind      = pitch_noise ? sixadsr_pkg::KIND_NOISE : sixadsr_pkg::KIND_TONE;
			prod.voice_res = sel_v;
			prod.chip      = chip;
			prod.value     = pitch_noise ? sixadsr_pkg::noise_period(pitch_note) : pitch_note;
		end
		case (state_q)
			ST_VB: begin
				prod_v         = amp_emit_q;
				prod.kind      = sixadsr_pkg::KIND_AMP;
				prod.voice_res = v_q;
				prod.chip      = chip;
				prod.value     = amp_val_q;
			end
			ST_MIX0: begin
				prod_v     = (lmix_q[0] != {2'b0, mix_q[0]});
				prod.kind  = sixadsr_pkg::KIND_MIXER;
				prod.value = {2'b0, mix_q[0]};
			end
			ST_MIX1: begin
				prod_v     = (chip_count == 2'd2) && (lmix_q[1] != {2'b0, mix_q[1]});
				prod.kind  = sixadsr_pkg::KIND_MIXER;
				prod.chip  = 1'b1;
				prod.value = {2'b0, mix_q[1]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < INSTRUMENTS; i++)
				tbl_q[i] <= '0;
			for (int k = 0; k < 6; k++) begin
				vinst_q[k] <= '0;
				phase_q[k] <= sixadsr_pkg::PHASE_OFF;
				amp_q[k]   <= '0;
				lout_q[k]  <= sixadsr_pkg::LAST_UNKNOWN;
				note_q[k]  <= '0;
				arp_q[k]   <= '0;
				noise_q[k] <= 1'b0;
			end
			for (int c = 0; c < 2; c++) begin
				lmix_q[c] <= sixadsr_pkg::LAST_UNKNOWN;
				mix_q[c]  <= sixadsr_pkg::MIXER_ALL;
			end
			state_q       <= ST_IDLE;
			v_q           <= '0;
			amp_emit_q    <= 1'b0;
			amp_val_q     <= '0;
			pend_v_q      <= 1'b0;
			pend_q        <= '0;
			result_strobe <= 1'b0;
			result        <= '0;
		end else begin
			result_strobe <= 1'b0;
			// A write is held back until the next one is produced or the request closes, so that the final one can carry last
			if (prod_v) begin
				if (pend_v_q) begin
					result_strobe <= 1'b1;
					result        <= pend_q;
				end
				pend_q   <= prod;
				pend_v_q <= 1'b1;
			end else if (state_q == ST_FLUSH && pend_v_q) begin
				result_strobe <= 1'b1;
				result        <= {pend_q[$bits(sixadsr_pkg::out_t)-1:1], 1'b1};
				pend_v_q      <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						case (head.data.op)
							sixadsr_pkg::CMD_NOTE_ON: begin
								noise_q[sel_v] <= inst.flg;
								note_q[sel_v]  <= head.data.note;
								arp_q[sel_v]   <= 2'd0;
								if (inst.atk == 8'd0) begin
									amp_q[sel_v]   <= {inst.peak, 4'b0};
									phase_q[sel_v] <= sixadsr_pkg::PHASE_FALL;
								end else begin
									amp_q[sel_v]   <= 8'd0;
									phase_q[sel_v] <= sixadsr_pkg::PHASE_RISE;
								end
								state_q <= ST_FLUSH;
							end
							sixadsr_pkg::CMD_NOTE_OFF:
								phase_q[sel_v] <= sixadsr_pkg::PHASE_FADE;
							sixadsr_pkg::CMD_SET_INSTR:
								vinst_q[sel_v] <= head.data.instrument;
							sixadsr_pkg::CMD_LOAD:
								tbl_q[IW'(head.data.instrument)] <= head.data.data;
							sixadsr_pkg::CMD_TICK: begin
								v_q      <= '0;
								mix_q[0] <= sixadsr_pkg::MIXER_ALL;
								mix_q[1] <= sixadsr_pkg::MIXER_ALL;
								state_q  <= ST_VA;
							end
							sixadsr_pkg::CMD_ALL_OFF: begin
								for (int k = 0; k < 6; k++) begin
									phase_q[k] <= sixadsr_pkg::PHASE_OFF;
									amp_q[k]   <= '0;
									lout_q[k]  <= sixadsr_pkg::LAST_UNKNOWN;
									note_q[k]  <= '0;
									arp_q[k]   <= '0;
									noise_q[k] <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_VA: begin
					amp_emit_q <= 1'b0;
					if (!skip) begin
						phase_q[sel_v] <= nph;
						amp_q[sel_v]   <= namp;
						if (arp_go)
							arp_q[sel_v] <= nstep;
						if (alev != 4'd0)
							mix_q[chip][mix_bit] <= 1'b0;
						if (aemit) begin
							lout_q[sel_v] <= {4'b0, alev};
							amp_emit_q    <= 1'b1;
							amp_val_q     <= {4'b0, aatt};
						end
					end
					state_q <= ST_VB;
				end
				ST_VB: begin
					if (v_q == sixadsr_pkg::VOICES - 3'd1) begin
						state_q <= ST_MIX0;
					end else begin
						v_q     <= v_q + 3'd1;
						state_q <= ST_VA;
					end
				end
				ST_MIX0: begin
					lmix_q[0] <= {2'b0, mix_q[0]};
					state_q   <= ST_MIX1;
				end
				ST_MIX1: begin
					if (chip_count == 2'd2)
						lmix_q[1] <= {2'b0, mix_q[1]};
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: dv/tb_six_voice_adsr_envelope_engine_core.sv
// Self-checking testbench for the six-voice envelope engine core.
module tb_six_voice_adsr_envelope_engine_core;
	timeunit 1ns;
	timeprecision 1ps;
	import sixadsr_pkg::*;

	// Write predictor and store of expected writes. It keeps its own copy of the
	// instrument table, per-voice envelope state and the two registers.
	class envelope_scoreboard;
		instr_t      patches [8];
		logic [2:0]  voice_patch [6];
		logic [2:0]  phase [6];
		logic [7:0]  level [6];
		logic [7:0]  level_sent [6];
		logic [7:0]  base_note [6];
		logic [1:0]  arp_pos [6];
		logic        on_noise [6];
		logic [7:0]  mixer_sent [2];
		logic [3:0]  atten;
		logic [1:0]  chips;
		out_t        pending_writes [$];
		int          errors;

		function void clear_voices();
			for (int k = 0; k < 6; k++) begin
				phase[k] = PHASE_OFF;
				level[k] = 0;
				level_sent[k] = 8'hFF;
				base_note[k] = 0;
				arp_pos[k] = 0;
				on_noise[k] = 0;
			end
		endfunction

		function new();
			for (int k = 0; k < 8; k++) patches[k] = '0;
			for (int k = 0; k < 6; k++) voice_patch[k] = 0;
			clear_voices();
			mixer_sent[0] = 8'hFF;
			mixer_sent[1] = 8'hFF;
			atten = 0;
			chips = 2;
			errors = 0;
		endfunction

		function void push_write(logic [1:0] kind, int v, logic chip, logic [7:0] value);
			out_t w;
			w.kind = kind;
			w.voice_res = v[2:0];
			w.chip = chip;
			w.value = value;
			w.last = 1'b0;
			pending_writes.push_back(w);
		endfunction

		// Pitch write: noise period from the note, or the note index for tones.
		function void push_pitch(int v, logic [7:0] n);
			logic chip;
			chip = (v >= 3);
			if (on_noise[v])
				push_write(KIND_NOISE, v, chip, n < 13 ? 8'd31 : (n > 43 ? 8'd1 : 8'd44 - n));
			else if (n < 96)
				push_write(KIND_TONE, v, chip, n);
		endfunction

		function void frame_tick();
			logic [5:0] mix [2];
			instr_t     p;
			int         amp, pk, su, a, off;
			logic       chip;
			mix[0] = 6'h3F;
			mix[1] = 6'h3F;
			for (int v = 0; v < 6; v++) begin
				p = patches[voice_patch[v]];
				chip = (v >= 3);
				amp = level[v];
				pk = p.peak * 16;
				su = p.sus * 16;
				if (phase[v] == PHASE_OFF && level_sent[v] == 0) continue;
				case (phase[v])
					PHASE_RISE: begin
						if (amp + p.atk >= pk) begin
							amp = pk;
							phase[v] = PHASE_FALL;
						end else amp += p.atk;
					end
					PHASE_FALL: begin
						if (p.dec == 0 || amp <= su + p.dec) begin
							amp = su;
							phase[v] = su != 0 ? PHASE_HOLD : PHASE_OFF;
						end else amp -= p.dec;
					end
					PHASE_FADE: begin
						if (p.rel == 0 || amp <= p.rel) begin
							amp = 0;
							phase[v] = PHASE_OFF;
						end else amp -= p.rel;
					end
					default: ;
				endcase
				level[v] = amp[7:0];
				if (phase[v] != PHASE_OFF && (p.ar1 != 0 || p.ar2 != 0)) begin
					arp_pos[v] = arp_pos[v] >= 2 ? 2'd0 : arp_pos[v] + 2'd1;
					off = arp_pos[v] == 1 ? p.ar1 : (arp_pos[v] == 2 ? p.ar2 : 0);
					push_pitch(v, 8'(base_note[v] + off));
				end
				a = (amp >> 4) & 15;
				if (a != 0) mix[chip][on_noise[v] ? 3 + v % 3 : v % 3] = 1'b0;
				if (a != level_sent[v]) begin
					level_sent[v] = a[7:0];
					a = a > atten ? a - atten : 0;
					push_write(KIND_AMP, v, chip, a[7:0]);
				end
			end
			if (mixer_sent[0] != {2'b00, mix[0]}) begin
				mixer_sent[0] = {2'b00, mix[0]};
				push_write(KIND_MIXER, 0, 1'b0, mixer_sent[0]);
			end
			if (chips == 2 && mixer_sent[1] != {2'b00, mix[1]}) begin
				mixer_sent[1] = {2'b00, mix[1]};
				push_write(KIND_MIXER, 0, 1'b1, mixer_sent[1]);
			end
		endfunction

		// Notes one accepted request and appends the writes it should cause.
		function void note_request(in_t r);
			int     first;
			instr_t p;
			first = pending_writes.size();
			case (r.cmd)
				CMD_NOTE_ON: if (r.voice < 6) begin
					p = patches[voice_patch[r.voice]];
					on_noise[r.voice] = p.flg;
					base_note[r.voice] = r.note;
					arp_pos[r.voice] = 0;
					push_pitch(r.voice, r.note);
					if (p.atk == 0) begin
						level[r.voice] = {p.peak, 4'b0};
						phase[r.voice] = PHASE_FALL;
					end else begin
						level[r.voice] = 0;
						phase[r.voice] = PHASE_RISE;
					end
				end
				CMD_NOTE_OFF: if (r.voice < 6) phase[r.voice] = PHASE_FADE;
				CMD_SET_INSTR: if (r.voice < 6) voice_patch[r.voice] = r.instrument;
				CMD_LOAD: patches[r.instrument] = {r.peak, r.attack_rate, r.decay_rate,
					r.sustain, r.release_rate, r.noise_flag, r.arp_first, r.arp_second};
				CMD_TICK: frame_tick();
				CMD_ALL_OFF: clear_voices();
				default: ;
			endcase
			if (pending_writes.size() > first)
				pending_writes[pending_writes.size() - 1].last = 1'b1;
		endfunction

		function void check_write(out_t got);
			out_t want;
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected write: expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = pending_writes.pop_front();
			if (got.kind !== want.kind || got.voice_res !== want.voice_res ||
			    got.chip !== want.chip || got.value !== want.value ||
			    got.last !== want.last) begin
				$display("%0t: write mismatch: expected %p, actual %p", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n, start, busy, result_strobe;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	in_t         req;
	out_t        result;

	envelope_scoreboard board;

	six_voice_adsr_envelope_engine_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_strobe(result_strobe), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Writes are sampled at the edge that closes their strobe cycle.
	always @(posedge clk) begin
		if (arst_n && result_strobe) board.check_write(result);
	end

	// One APB register write: a setup phase, then the access phase.
	task automatic write_register(logic [1:0] index, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 1'b0} << 1;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == ADDR_ATTENUATION) board.atten = data[3:0];
		else board.chips = data[1:0];
	endtask

	// Offers one request, after a random gap when allowed, and holds it until it is taken.
	// The request is noted in the scoreboard at the edge that accepts it.
	// Start stays high after acceptance until a gap or a drain lowers it.
	task automatic send_request(in_t r, bit allow_gap);
		int gap;
		gap = allow_gap ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(r);
	endtask

	// Waits until every expected write has arrived, then lets the engine settle
	// so that requests without writes have also finished before a register write.
	task automatic drain();
		start <= 1'b0;
		while (board.pending_writes.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic in_t make_request(logic [2:0] cmd, logic [2:0] v);
		in_t r;
		r = in_t'({$urandom, $urandom, 2'($urandom)});
		r.cmd = cmd;
		r.voice = v;
		return r;
	endfunction

	function automatic in_t make_patch(logic [2:0] slot);
		in_t r;
		r = make_request(CMD_LOAD, 0);
		r.instrument = slot;
		r.peak = 4'($urandom_range(4, 15));
		r.attack_rate = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(8, 120));
		r.decay_rate = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(4, 80));
		r.sustain = 4'($urandom_range(0, 12));
		r.release_rate = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(8, 100));
		if ($urandom_range(0, 1)) begin
			r.arp_first = 0;
			r.arp_second = 0;
		end else begin
			r.arp_first = 8'($urandom_range(0, 12));
			r.arp_second = 8'($urandom_range(0, 12));
		end
		return r;
	endfunction

	in_t r;
	int  pick;

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: ticks on a reset engine, all-ones and zero patches, bad
		// voices, unknown commands and noise period edges.
		send_request(make_request(CMD_TICK, 0), 0);
		r = make_request(CMD_LOAD, 0);
		r.instrument = 7;
		r = in_t'({r[$bits(in_t)-1 -: 9], {(($bits(in_t)) - 9){1'b1}}});
		r.instrument = 7;
		send_request(r, 0);
		r = make_patch(1);
		r.noise_flag = 1;
		send_request(r, 0);
		r = make_request(CMD_SET_INSTR, 0);
		r.instrument = 7;
		send_request(r, 1);
		r = make_request(CMD_SET_INSTR, 5);
		r.instrument = 1;
		send_request(r, 1);
		send_request(make_request(CMD_SET_INSTR, 7), 0);
		for (int k = 0; k < 8; k++) begin
			r = make_request(CMD_NOTE_ON, k % 2 != 0 ? 3'd0 : 3'd5);
			r.note = k == 0 ? 8'd0 : k == 1 ? 8'd12 : k == 2 ? 8'd13 : k == 3 ? 8'd43 :
				k == 4 ? 8'd44 : k == 5 ? 8'd95 : k == 6 ? 8'd96 : 8'd255;
			send_request(r, 0);
		end
		send_request(make_request(CMD_NOTE_ON, 6), 0);
		send_request(make_request(CMD_NOTE_OFF, 7), 0);
		send_request(make_request(3'd6, 0), 1);
		send_request(make_request(3'd7, 2), 1);
		repeat (3) send_request(make_request(CMD_TICK, 0), 1);
		send_request(make_request(CMD_NOTE_OFF, 0), 0);
		send_request(make_request(CMD_TICK, 0), 0);
		send_request(make_request(CMD_ALL_OFF, 0), 0);
		send_request(make_request(CMD_TICK, 0), 0);

		// Random part in four register settings, the extremes among them.
		for (int phase_no = 0; phase_no < 4; phase_no++) begin
			drain();
			write_register(ADDR_ATTENUATION, phase_no == 1 ? 15 : phase_no == 3 ? 0 :
				$urandom_range(1, 14));
			write_register(ADDR_CHIP_COUNT, phase_no % 2 ? 1 : 2);
			for (int k = 0; k < 8; k++)
				send_request(make_patch(k[2:0]), 1'($urandom_range(0, 1)));
			for (int n = 0; n < 85; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) r = make_request(CMD_TICK, 0);
				else if (pick < 60) begin
					r = make_request(CMD_NOTE_ON, 3'($urandom_range(0, 5)));
					if ($urandom_range(0, 3) != 0) r.note = 8'($urandom_range(0, 100));
				end else if (pick < 72)
					r = make_request(CMD_NOTE_OFF, 3'($urandom_range(0, 5)));
				else if (pick < 80) r = make_request(CMD_SET_INSTR, 3'($urandom_range(0, 5)));
				else if (pick < 86) r = make_patch(3'($urandom_range(0, 7)));
				else if (pick < 89) r = make_request(CMD_ALL_OFF, 0);
				else r = make_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
				send_request(r, $urandom_range(0, 2) != 0);
			end
		end
		drain();

		if (board.errors == 0 && board.pending_writes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

// File: six_voice_adsr_envelope_engine_core.f
hw/rtl/sixadsr_pkg.sv
hw/rtl/sixadsr_front.sv
hw/rtl/sixadsr_queue.sv
hw/rtl/sixadsr_back.sv
hw/rtl/six_voice_adsr_envelope_engine_core.sv
dv/tb_six_voice_adsr_envelope_engine_core.sv
